[sv/aum_pkg.sv]
// ----------------------------------------------------------------------------
// aum_pkg
// Types, constants and the reciprocal table shared by the alpha un-premultiply
// pipeline stages.
// ----------------------------------------------------------------------------
package aum_pkg;

    localparam int BYTE_W    = 8;
    localparam int PIXEL_W   = 4 * BYTE_W;
    localparam int SCALED_W  = 2 * BYTE_W;          // channel * 255 fits in 16 bits
    localparam int RECIP_SH  = 24;                  // fixed-point shift of the reciprocal
    localparam int RECIP_W   = RECIP_SH + 1;        // ceil(2^24 / 1) needs 25 bits
    localparam int PROD_W    = SCALED_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - RECIP_SH;   // integer part of the product
    localparam int NUM_CHAN  = 3;
    localparam int TABLE_D   = 1 << BYTE_W;

    localparam logic [BYTE_W-1:0] FULL_SCALE = 8'hFF;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [RECIP_W-1:0]  recip_t;
    typedef logic [SCALED_W-1:0] scaled_t;
    typedef logic [QUOT_W-1:0]   quot_t;
    typedef recip_t recip_table_t [TABLE_D];

    // Stage 1 -> stage 2: scaled colors and the reciprocal of alpha
    typedef struct packed {
        byte_t                  alpha;
        recip_t                 recip;
        scaled_t [NUM_CHAN-1:0] scaled;
    } scale_data_t;

    // Stage 2 -> stage 3: integer quotients before saturation
    typedef struct packed {
        byte_t                alpha;
        quot_t [NUM_CHAN-1:0] quot;
    } mult_data_t;

    // Table of ceil(2^24 / a); entry 0 is zero so a transparent pixel maps to 0.
    // Built at elaboration by restoring long division.
    function automatic recip_table_t build_recip_table();
        recip_table_t         tbl;
        logic [RECIP_W-1:0]   num;
        logic [BYTE_W:0]      rem;
        logic [RECIP_W-1:0]   quo;
        tbl[0] = '0;
        for (int a = 1; a < TABLE_D; a++) begin
            num = RECIP_W'(1 << RECIP_SH) + RECIP_W'(a - 1);
            rem = '0;
            quo = '0;
            for (int i = RECIP_W - 1; i >= 0; i--) begin
                rem = {rem[BYTE_W-1:0], num[i]};
                if (rem >= (BYTE_W+1)'(a)) begin
                    rem    = rem - (BYTE_W+1)'(a);
                    quo[i] = 1'b1;
                end
            end
            tbl[a] = quo;
        end
        return tbl;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip_table();

endpackage

[sv/aum_scale.sv]
// ----------------------------------------------------------------------------
// aum_scale
// Stage 1: splits the ARGB word, scales each color by 255 and looks up the
// reciprocal of alpha.
// ----------------------------------------------------------------------------
module aum_scale import aum_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIXEL_W-1:0]   in_pixel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scale_data_t          out_data
);

    logic        valid_reg;
    scale_data_t data_reg;
    scale_data_t data_next;
    byte_t       alpha;
    byte_t       chan [NUM_CHAN];

    assign alpha   = in_pixel[4*BYTE_W-1:3*BYTE_W];
    assign chan[2] = in_pixel[3*BYTE_W-1:2*BYTE_W];    // red
    assign chan[1] = in_pixel[2*BYTE_W-1:BYTE_W];      // green
    assign chan[0] = in_pixel[BYTE_W-1:0];             // blue

    always_comb begin
        data_next.alpha = alpha;
        data_next.recip = RECIP_TABLE[alpha];
        for (int i = 0; i < NUM_CHAN; i++) begin
            // c * 255 = (c << 8) - c
            data_next.scaled[i] = {chan[i], {BYTE_W{1'b0}}} - SCALED_W'(chan[i]);
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/aum_mult.sv]
// ----------------------------------------------------------------------------
// aum_mult
// Stage 2: multiplies each scaled color by the alpha reciprocal and keeps the
// integer part, which is the exact floor quotient.
// ----------------------------------------------------------------------------
module aum_mult import aum_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  scale_data_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mult_data_t  out_data
);

    logic        valid_reg;
    mult_data_t  data_reg;
    mult_data_t  data_next;
    logic [PROD_W-1:0] prod [NUM_CHAN];

    // The reciprocal error stays below 2^-8 of the quotient step, so no
    // correction is needed for numerators under 2^16.
    always_comb begin
        data_next.alpha = in_data.alpha;
        for (int i = 0; i < NUM_CHAN; i++) begin
            prod[i] = PROD_W'(in_data.scaled[i]) * PROD_W'(in_data.recip);
            data_next.quot[i] = prod[i][PROD_W-1:RECIP_SH];
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/aum_sat.sv]
// ----------------------------------------------------------------------------
// aum_sat
// Stage 3: saturates the quotients at 255 and packs the RGBA result into the
// output register.
// ----------------------------------------------------------------------------
module aum_sat import aum_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mult_data_t           in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIXEL_W-1:0]   out_pixel
);

    logic               valid_reg;
    logic [PIXEL_W-1:0] data_reg;
    logic [PIXEL_W-1:0] data_next;
    byte_t              sat [NUM_CHAN];

    // Alpha 0 yields quotient 0 and alpha 255 yields the color itself, so
    // both corner cases fall out of the table and need no extra select.
    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            sat[i] = (|in_data.quot[i][QUOT_W-1:BYTE_W]) ? FULL_SCALE
                                                         : in_data.quot[i][BYTE_W-1:0];
        end
        data_next = {in_data.alpha, sat[0], sat[1], sat[2]};
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = data_reg;

endmodule

[sv/alpha_unpremultiply_rgba.sv]
// ----------------------------------------------------------------------------
// alpha_unpremultiply_rgba
// Converts premultiplied ARGB words into straight-alpha RGBA bytes.
// ----------------------------------------------------------------------------
// Each input word carries alpha in bits 31..24 and red, green, blue below it.
// Every color becomes floor(color * 255 / alpha), saturated at 255; alpha 0
// gives black, alpha 255 passes colors unchanged, and alpha itself passes
// through. The block is a three-stage pipeline (scale and reciprocal lookup,
// multiply, saturate) and accepts one transaction per clock unless the output
// stalls. Each stage holds its transaction on a downstream stall and takes
// new data whenever it is empty, so bubbles are squeezed out. No state is kept
// between pixels.
module alpha_unpremultiply_rgba import aum_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIXEL_W-1:0]   s_tdata,   // [31:0] premultiplied_pixel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIXEL_W-1:0]   m_tdata    // [7:0] out_red, [15:8] out_green,
                                            // [23:16] out_blue, [31:24] out_alpha
);

    logic        s1_valid;
    logic        s1_ready;
    scale_data_t s1_data;
    logic        s2_valid;
    logic        s2_ready;
    mult_data_t  s2_data;

    aum_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (s_tdata),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    aum_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    aum_sat u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alpha un-premultiply pipeline.
// ----------------------------------------------------------------------------
// Streams premultiplied ARGB words into the block: a directed set of corner
// pixels first, then random pixels. The largest share of random pixels are valid
// premultiplied colors; the rest are transparent, opaque, near-zero alpha or raw noise.
// A small scoreboard predicts each RGBA result when its input transaction is
// accepted and compares every output byte in order. Both stream sides idle at
// random in the first two of three phases; the input pauses once until the pipeline drains.
// ----------------------------------------------------------------------------
module tb;
    import aum_pkg::*;

    localparam int          HALF_PERIOD = 5;
    localparam int          RESET_CYCLES = 7;
    localparam int          PHASE_ITEMS = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_REPORTS = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SCALE = 255;

    localparam logic [PIXEL_W-1:0] DIRECTED_PX [20] = '{
        32'h0000_0000, 32'h00FF_FFFF, 32'h00A5_5A01, 32'hFF00_0000,
        32'hFFFF_FFFF, 32'hFF12_3456, 32'h0101_0100, 32'h01FF_8002,
        32'h0100_0000, 32'h0201_0200, 32'h80FF_8040, 32'h807F_8001,
        32'hFEFE_FD01, 32'hFEFF_FFFF, 32'h7F7F_7F7F, 32'h55AA_55AA,
        32'hAA55_AA55, 32'hC0C1_BF00, 32'h0302_0100, 32'h4040_2010
    };

    // Field order matches m_tdata: red in the lowest byte
    typedef struct packed {
        byte_t alpha;
        byte_t blue;
        byte_t green;
        byte_t red;
    } rgba_t;

    class rgba_scoreboard;
        rgba_t expected_rgba [$];
        int    mismatches;

        function new();
            mismatches = 0;
        endfunction

        function rgba_t unpremultiply(logic [PIXEL_W-1:0] argb);
            byte_t       alpha;
            byte_t       chan [3];
            byte_t       straight [3];
            int unsigned quot;
            rgba_t       res;
            alpha   = argb[31:24];
            chan[0] = argb[23:16];
            chan[1] = argb[15:8];
            chan[2] = argb[7:0];
            for (int i = 0; i < 3; i++) begin
                if (alpha == '0) begin
                    quot = 0;
                end else if (alpha == FULL_SCALE) begin
                    quot = 32'(chan[i]);
                end else begin
                    quot = (32'(chan[i]) * SCALE) / 32'(alpha);
                    if (quot > SCALE) quot = SCALE;
                end
                straight[i] = quot[7:0];
            end
            res.red   = straight[0];
            res.green = straight[1];
            res.blue  = straight[2];
            res.alpha = alpha;
            return res;
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] argb);
            expected_rgba.insert(expected_rgba.size(), unpremultiply(argb));
        endfunction

        function void check_result(logic [PIXEL_W-1:0] word);
            rgba_t got;
            rgba_t want;
            got = word;
            if (expected_rgba.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result %h at %0t", word, $realtime);
                mismatches++;
            end else begin
                want = expected_rgba[0];
                expected_rgba.delete(0);
                if (got.red != want.red || got.green != want.green ||
                    got.blue != want.blue || got.alpha != want.alpha) begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch at %0t: r/g/b/a expected %h %h %h %h got %h %h %h %h",
                                 $realtime, want.red, want.green, want.blue, want.alpha,
                                 got.red, got.green, got.blue, got.alpha);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_rgba.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [PIXEL_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [PIXEL_W-1:0] m_tdata;

    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;
    int unsigned    cycles = 0;
    rgba_scoreboard sb;

    alpha_unpremultiply_rgba u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Valid premultiplied colors as the largest share, plus transparent, opaque,
    // tiny-alpha and unconstrained words
    function automatic logic [PIXEL_W-1:0] random_pixel();
        int unsigned        mode;
        byte_t              alpha;
        logic [PIXEL_W-1:0] argb;
        mode = $urandom_range(99);
        argb = $urandom;
        if (mode < 45) begin
            alpha = 8'($urandom_range(255));
            argb  = {alpha, 8'($urandom_range(alpha)), 8'($urandom_range(alpha)),
                     8'($urandom_range(alpha))};
        end else if (mode < 57) begin
            argb[31:24] = '0;
        end else if (mode < 69) begin
            argb[31:24] = FULL_SCALE;
        end else if (mode < 77) begin
            argb[31:24] = 8'($urandom_range(3, 1));
        end
        return argb;
    endfunction

    task automatic send_pixel(logic [PIXEL_W-1:0] argb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= argb;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel(argb);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct <= 21;
        recv_idle_pct <= 62;
        @(posedge aclk);

        foreach (DIRECTED_PX[i]) send_pixel(DIRECTED_PX[i]);
        repeat (PHASE_ITEMS) send_pixel(random_pixel());

        // hold off input until every result is out
        drain_pipeline();
        send_idle_pct <= 62;
        recv_idle_pct <= 21;
        @(posedge aclk);
        repeat (PHASE_ITEMS) send_pixel(random_pixel());

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        repeat (PHASE_ITEMS) send_pixel(random_pixel());

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
